// ----- src/rti_pkg.sv -----
// Types and constants shared by the ray/triangle intersection block.
`default_nettype none
package rti_pkg;
  localparam int CoordWidth = 20;
  localparam int FracBits   = 8;
  localparam int WideWidth  = 64;
  localparam int IdxWidth   = 2;
  localparam int VertWidth  = 3 * CoordWidth;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int QBits      = CoordWidth + FracBits;
  localparam int PtWidth    = CoordWidth + QBits + 2;

  localparam logic [IdxWidth-1:0] RegVertexA = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] RegVertexB = IdxWidth'(1);
  localparam logic [IdxWidth-1:0] RegVertexC = IdxWidth'(2);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic signed [WideWidth-1:0]  wide_t;
  typedef logic [QBits:0]               quot_t;
  typedef logic signed [PtWidth-1:0]    pt_t;

  localparam pt_t SatHi = pt_t'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
  localparam pt_t SatLo = -SatHi - pt_t'(1);

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t direction_x;
    coord_t direction_y;
    coord_t direction_z;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    coord_t [2:0]     org;
    coord_t [2:0]     dir;
  } rti_side_t;
endpackage
`default_nettype wire

// ----- src/rti_div.sv -----
// Pipelined restoring divider: clamped quotient with fraction bits, one bit per stage.
`default_nettype none
module rti_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic [rti_pkg::WideWidth-1:0]      num,
  input  wire logic [rti_pkg::WideWidth-1:0]      den,
  input  wire rti_pkg::rti_side_t                 in_side,
  output logic                                    out_valid,
  output rti_pkg::quot_t                          quot,
  output rti_pkg::rti_side_t                      out_side
);
  localparam int QB = rti_pkg::QBits;
  localparam int DW = rti_pkg::WideWidth + QB + 1;

  logic                    v_r    [QB:0];
  logic [DW-1:0]           rem_r  [QB:0];
  logic [DW-1:0]           den_r  [QB:0];
  logic [QB-1:0]           q_r    [QB:0];
  logic                    clamp_r[QB:0];
  rti_pkg::rti_side_t      side_r [QB:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    rem_r[0]   <= DW'(num) << rti_pkg::FracBits;
    den_r[0]   <= DW'(den);
    q_r[0]     <= '0;
    clamp_r[0] <= DW'(num) >= (DW'(den) << rti_pkg::CoordWidth);
    side_r[0]  <= in_side;
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K = QB - 1 - j;
    logic [DW-1:0] sub_w;
    logic          take_w;
    assign sub_w  = den_r[j] << K;
    assign take_w = rem_r[j] >= sub_w;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
      rem_r[j+1]   <= take_w ? rem_r[j] - sub_w : rem_r[j];
      den_r[j+1]   <= den_r[j];
      q_r[j+1]     <= q_r[j] | (QB'(take_w) << K);
      clamp_r[j+1] <= clamp_r[j];
      side_r[j+1]  <= side_r[j];
    end
  end

  assign out_valid = v_r[QB];
  assign quot      = clamp_r[QB] ? (rti_pkg::quot_t'(1) << QB) : {1'b0, q_r[QB]};
  assign out_side  = side_r[QB];
endmodule
`default_nettype wire

// ----- src/ray_triangle_intersect.sv -----
// Each accepted start yields one out_valid strobe for that ray.
// Throughput: one ray per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 28-stage one-bit-per-stage distance divider.
// Synchronous active-low reset clears all valid bits and the three vertex registers.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none
module ray_triangle_intersect (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire rti_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  output rti_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rti_pkg::IdxWidth-1:0]       cfg_index,
  input  wire logic [rti_pkg::VertWidth-1:0]      cfg_data
);
  localparam int Latency = rti_pkg::QBits + 11;
  localparam int LoW     = rti_pkg::DiffWidth;
  localparam int HiTop   = rti_pkg::CrossWidth - 1;

  logic [rti_pkg::VertWidth-1:0] va_r, vb_r, vc_r;
  rti_pkg::coord_t [2:0] a_w, b_w, c_w, o_w, d_w;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
      vb_r <= '0;
      vc_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rti_pkg::RegVertexA: va_r <= cfg_data;
        rti_pkg::RegVertexB: vb_r <= cfg_data;
        rti_pkg::RegVertexC: vc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_w = va_r;
  assign b_w = vb_r;
  assign c_w = vc_r;
  assign o_w = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
  assign d_w = {in_data.direction_z, in_data.direction_y, in_data.direction_x};

  // stage 1: edges
  logic v1_r;
  rti_pkg::coord_t [2:0] o1_r, d1_r;
  rti_pkg::diff_t  [2:0] e1_1_r, e2_1_r, s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    o1_r <= o_w;
    d1_r <= d_w;
    for (int i = 0; i < 3; i++) begin
      e1_1_r[i] <= rti_pkg::diff_t'(b_w[i]) - rti_pkg::diff_t'(a_w[i]);
      e2_1_r[i] <= rti_pkg::diff_t'(c_w[i]) - rti_pkg::diff_t'(a_w[i]);
      s1_r[i]   <= rti_pkg::diff_t'(o_w[i]) - rti_pkg::diff_t'(a_w[i]);
    end
  end

  // stage 2: cross product partial products
  logic v2_r;
  rti_pkg::coord_t [2:0] o2_r, d2_r;
  rti_pkg::diff_t  [2:0] e1_2_r, e2_2_r, s2_r;
  rti_pkg::prod_t  [5:0] hp_r, qp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    o2_r   <= o1_r;
    d2_r   <= d1_r;
    e1_2_r <= e1_1_r;
    e2_2_r <= e2_1_r;
    s2_r   <= s1_r;
    for (int i = 0; i < 3; i++) begin
      hp_r[2*i]   <= rti_pkg::prod_t'(d1_r[(i+1)%3]) * rti_pkg::prod_t'(e2_1_r[(i+2)%3]);
      hp_r[2*i+1] <= rti_pkg::prod_t'(d1_r[(i+2)%3]) * rti_pkg::prod_t'(e2_1_r[(i+1)%3]);
      qp_r[2*i]   <= rti_pkg::prod_t'(s1_r[(i+1)%3]) * rti_pkg::prod_t'(e1_1_r[(i+2)%3]);
      qp_r[2*i+1] <= rti_pkg::prod_t'(s1_r[(i+2)%3]) * rti_pkg::prod_t'(e1_1_r[(i+1)%3]);
    end
  end

  // stage 3: cross products
  logic v3_r;
  rti_pkg::coord_t [2:0] o3_r, d3_r;
  rti_pkg::diff_t  [2:0] e1_3_r, e2_3_r, s3_r;
  rti_pkg::cross_t [2:0] h3_r, q3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    o3_r   <= o2_r;
    d3_r   <= d2_r;
    e1_3_r <= e1_2_r;
    e2_3_r <= e2_2_r;
    s3_r   <= s2_r;
    for (int i = 0; i < 3; i++) begin
      h3_r[i] <= rti_pkg::cross_t'(hp_r[2*i]) - rti_pkg::cross_t'(hp_r[2*i+1]);
      q3_r[i] <= rti_pkg::cross_t'(qp_r[2*i]) - rti_pkg::cross_t'(qp_r[2*i+1]);
    end
  end

  // stage 4: dot product partial products, cross terms split in low and high halves
  logic v4_r;
  rti_pkg::coord_t [2:0] o4_r, d4_r;
  rti_pkg::cross_t [2:0] hl_w, hh_w, ql_w, qh_w;
  rti_pkg::cross_t [2:0] det_lo_r, det_hi_r, un_lo_r, un_hi_r;
  rti_pkg::cross_t [2:0] vn_lo_r, vn_hi_r, tn_lo_r, tn_hi_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hl_w[i] = rti_pkg::cross_t'($signed({1'b0, h3_r[i][LoW-1:0]}));
      hh_w[i] = rti_pkg::cross_t'($signed(h3_r[i][HiTop:LoW]));
      ql_w[i] = rti_pkg::cross_t'($signed({1'b0, q3_r[i][LoW-1:0]}));
      qh_w[i] = rti_pkg::cross_t'($signed(q3_r[i][HiTop:LoW]));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    o4_r <= o3_r;
    d4_r <= d3_r;
    for (int i = 0; i < 3; i++) begin
      det_lo_r[i] <= rti_pkg::cross_t'(e1_3_r[i]) * hl_w[i];
      det_hi_r[i] <= rti_pkg::cross_t'(e1_3_r[i]) * hh_w[i];
      un_lo_r[i]  <= rti_pkg::cross_t'(s3_r[i]) * hl_w[i];
      un_hi_r[i]  <= rti_pkg::cross_t'(s3_r[i]) * hh_w[i];
      vn_lo_r[i]  <= rti_pkg::cross_t'(d3_r[i]) * ql_w[i];
      vn_hi_r[i]  <= rti_pkg::cross_t'(d3_r[i]) * qh_w[i];
      tn_lo_r[i]  <= rti_pkg::cross_t'(e2_3_r[i]) * ql_w[i];
      tn_hi_r[i]  <= rti_pkg::cross_t'(e2_3_r[i]) * qh_w[i];
    end
  end

  // stage 4b: dot product terms
  logic v4b_r;
  rti_pkg::coord_t [2:0] o4b_r, d4b_r;
  rti_pkg::wide_t  [2:0] det_t_r, un_t_r, vn_t_r, tn_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4b_r <= 1'b0;
    end else begin
      v4b_r <= v4_r;
    end
    o4b_r <= o4_r;
    d4b_r <= d4_r;
    for (int i = 0; i < 3; i++) begin
      det_t_r[i] <= (rti_pkg::wide_t'(det_hi_r[i]) <<< LoW) + rti_pkg::wide_t'(det_lo_r[i]);
      un_t_r[i]  <= (rti_pkg::wide_t'(un_hi_r[i]) <<< LoW) + rti_pkg::wide_t'(un_lo_r[i]);
      vn_t_r[i]  <= (rti_pkg::wide_t'(vn_hi_r[i]) <<< LoW) + rti_pkg::wide_t'(vn_lo_r[i]);
      tn_t_r[i]  <= (rti_pkg::wide_t'(tn_hi_r[i]) <<< LoW) + rti_pkg::wide_t'(tn_lo_r[i]);
    end
  end

  // stage 5: dot product sums
  logic v5_r;
  rti_pkg::coord_t [2:0] o5_r, d5_r;
  rti_pkg::wide_t det5_r, un5_r, vn5_r, tn5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4b_r;
    end
    o5_r   <= o4b_r;
    d5_r   <= d4b_r;
    det5_r <= det_t_r[0] + det_t_r[1] + det_t_r[2];
    un5_r  <= un_t_r[0] + un_t_r[1] + un_t_r[2];
    vn5_r  <= vn_t_r[0] + vn_t_r[1] + vn_t_r[2];
    tn5_r  <= tn_t_r[0] + tn_t_r[1] + tn_t_r[2];
  end

  // stage 6: sign normalize
  logic v6_r, zero6_r;
  rti_pkg::coord_t [2:0] o6_r, d6_r;
  rti_pkg::wide_t det6_r, un6_r, vn6_r, tn6_r;
  logic neg5_w;
  assign neg5_w = det5_r < 0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    o6_r    <= o5_r;
    d6_r    <= d5_r;
    zero6_r <= det5_r == '0;
    det6_r  <= neg5_w ? -det5_r : det5_r;
    un6_r   <= neg5_w ? -un5_r : un5_r;
    vn6_r   <= neg5_w ? -vn5_r : vn5_r;
    tn6_r   <= neg5_w ? -tn5_r : tn5_r;
  end

  // stage 7: inside and distance tests
  logic v7_r;
  rti_pkg::rti_side_t side7_r;
  rti_pkg::wide_t tn7_r, det7_r, uv6_w;
  logic miss6_w;
  assign uv6_w   = un6_r + vn6_r;
  assign miss6_w = zero6_r || (un6_r < 0) || (un6_r > det6_r) || (vn6_r < 0)
                   || (uv6_w > det6_r) || (tn6_r <= 0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    side7_r.hit <= !miss6_w;
    side7_r.org <= o6_r;
    side7_r.dir <= d6_r;
    tn7_r       <= tn6_r;
    det7_r      <= det6_r;
  end

  logic               vq_w;
  rti_pkg::quot_t     t_w;
  rti_pkg::rti_side_t sideq_w;

  rti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v7_r),
    .num      (tn7_r),
    .den      (det7_r),
    .in_side  (side7_r),
    .out_valid(vq_w),
    .quot     (t_w),
    .out_side (sideq_w)
  );

  // scale direction by distance
  logic vm_r, hitm_r;
  rti_pkg::coord_t [2:0] om_r;
  rti_pkg::pt_t    [2:0] pm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vq_w;
    end
    hitm_r <= sideq_w.hit;
    om_r   <= sideq_w.org;
    for (int i = 0; i < 3; i++) begin
      pm_r[i] <= rti_pkg::pt_t'(sideq_w.dir[i]) * rti_pkg::pt_t'($signed({1'b0, t_w}));
    end
  end

  // add origin, saturate, zero on miss
  rti_pkg::pt_t    [2:0] sum_w;
  rti_pkg::coord_t [2:0] pt_w;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = (pm_r[i] >>> rti_pkg::FracBits) + rti_pkg::pt_t'(om_r[i]);
      if (!hitm_r) begin
        pt_w[i] = '0;
      end else if (sum_w[i] > rti_pkg::SatHi) begin
        pt_w[i] = rti_pkg::coord_t'(rti_pkg::SatHi);
      end else if (sum_w[i] < rti_pkg::SatLo) begin
        pt_w[i] = rti_pkg::coord_t'(rti_pkg::SatLo);
      end else begin
        pt_w[i] = rti_pkg::coord_t'(sum_w[i]);
      end
    end
  end

  logic               out_valid_r;
  rti_pkg::out_item_t out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vm_r;
    end
    out_data_r.hit     <= hitm_r;
    out_data_r.point_x <= pt_w[0];
    out_data_r.point_y <= pt_w[1];
    out_data_r.point_z <= pt_w[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.point_x == '0 && out_data.point_y == '0
                                   && out_data.point_z == '0)
    else $error("miss beat carries a nonzero point");

  a_beat_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Latency))
    else $error("result beat without a matching accepted ray");

  a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##Latency out_valid)
    else $error("accepted ray produced no result beat");
endmodule
`default_nettype wire
